// ===== hw/rtl/min_plus_row_reduce_macros.svh =====
// Assertion macros used by the min-plus row reduce checker.
`ifndef MIN_PLUS_ROW_REDUCE_MACROS_SVH
`define MIN_PLUS_ROW_REDUCE_MACROS_SVH

// Next-cycle implication, quiet while reset is high.
`define MPRR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("min-plus row reduce: next-cycle property violated");

// Next-cycle implication that also covers the reset cycles.
`define MPRR_ASSERT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("min-plus row reduce: reset property violated");

`endif

// ===== hw/rtl/mprr_pkg.sv =====
// Types and constants shared by the min-plus row reduce block.
`default_nettype none

package mprr_pkg;

   // Width of the row and column size registers.
   localparam int DIM_W = 11;
   // Width of the column and row indexes carried in a result.
   localparam int IDX_OUT_W = 10;
   // Reset value of both size registers.
   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   // Register indexes on the configuration port.
   typedef enum logic [0:0] {
      REG_NUM_ROWS = 1'b0,
      REG_NUM_COLS = 1'b1
   } reg_idx_type;

   // Position flags of an item in the matrix.
   typedef struct packed {
      logic first_col;
      logic last_col;
      logic last_row;
   } pos_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/min_plus_row_reduce.sv =====
// Min-plus matrix-vector product: running row minimum and argmin in row memories.
`default_nettype none

// Takes one matrix element per cycle, column-major, each with the vector entry of
// its column, and keeps the running minimum of element+entry and its first column
// for every row in two single-port-write synchronous memories. Each element reads
// its row when taken and writes the updated minimum back as it leaves the update
// stage; when the next element hits the same row (one-row matrices) the written
// value is forwarded. Sustained rate is one element per clock while the output is
// not stalled; each result is registered as its element leaves the update stage.
// Elements of the last column give one result each, in row order, with pass_done
// on the last row. The memories need no clearing: column 0 overwrites every row
// before it is read. Any write of num_rows or num_cols restarts the pass at row 0,
// column 0; 0 counts as 1 and values above MAX_ROWS or MAX_COLS saturate.
module min_plus_row_reduce
   import mprr_pkg::*;
#(
   parameter int MAX_ROWS   = 1024,
   parameter int MAX_COLS   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // element input
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_cell_value,
   input  wire logic signed [DATA_WIDTH-1:0] req_column_offset,
   // result output
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH:0]        rsp_row_min,
   output logic [IDX_OUT_W-1:0]              rsp_row_argmin,
   output logic [IDX_OUT_W-1:0]              rsp_row_number,
   output logic                              rsp_pass_done,
   // configuration
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [2:0]                   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NRW = $clog2(MAX_ROWS + 1);
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int SW  = DATA_WIDTH + 1;

   // configuration registers
   logic [DIM_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [DIM_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [NRW-1:0]   num_rows;
   logic [NCW-1:0]   num_cols;
   logic             cfg_write;
   reg_idx_type      cfg_idx;

   // position counters
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic [CW-1:0] col_pos_ff, col_pos_in;
   pos_ctl_type   pos_ctl;

   // read stage
   logic                 req_xfer;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_adv;
   logic signed [SW-1:0] s1_sum_ff;
   logic [RW-1:0]        s1_row_ff;
   logic [IDX_OUT_W-1:0] s1_col_ff;
   pos_ctl_type          s1_ctl_ff;
   logic                 fwd_ff, fwd_in;
   logic signed [SW-1:0] rd_sum_ff;
   logic [IDX_OUT_W-1:0] rd_col_ff;
   logic signed [SW-1:0] wb_sum_ff;
   logic [IDX_OUT_W-1:0] wb_col_ff;
   logic signed [SW-1:0] base_sum;
   logic [IDX_OUT_W-1:0] base_col;
   logic signed [SW-1:0] new_sum;
   logic [IDX_OUT_W-1:0] new_col;
   logic                 take_new;

   // row memories
   logic signed [SW-1:0] best_sum_ff    [MAX_ROWS];
   logic [IDX_OUT_W-1:0] best_column_ff [MAX_ROWS];

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_min_ff;
   logic [IDX_OUT_W-1:0] rsp_argmin_ff;
   logic [IDX_OUT_W-1:0] rsp_row_ff;
   logic                 rsp_done_ff;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_idx   = reg_idx_type'(paddr[2]);

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      prdata      = '0;
      case (cfg_idx)
         REG_NUM_ROWS: begin
            prdata = 32'(rows_cfg_ff);
            if (cfg_write) rows_cfg_in = pwdata[DIM_W-1:0];
         end
         REG_NUM_COLS: begin
            prdata = 32'(cols_cfg_ff);
            if (cfg_write) cols_cfg_in = pwdata[DIM_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   // saturate the sizes to 1..MAX
   always_comb begin
      if (rows_cfg_ff == '0) begin
         num_rows = NRW'(1);
      end else if (32'(rows_cfg_ff) > 32'(MAX_ROWS)) begin
         num_rows = NRW'(MAX_ROWS);
      end else begin
         num_rows = NRW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         num_cols = NCW'(1);
      end else if (32'(cols_cfg_ff) > 32'(MAX_COLS)) begin
         num_cols = NCW'(MAX_COLS);
      end else begin
         num_cols = NCW'(cols_cfg_ff);
      end
   end

   // ---------------- position counters ----------------
   assign req_xfer = req_valid && !req_stall;

   always_comb begin
      pos_ctl.first_col = (col_pos_ff == '0);
      pos_ctl.last_col  = (32'(col_pos_ff) + 32'd1) >= 32'(num_cols);
      pos_ctl.last_row  = (32'(row_pos_ff) + 32'd1) >= 32'(num_rows);
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (cfg_write) begin
         // restart the pass
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (req_xfer) begin
         if (pos_ctl.last_row) begin
            row_pos_in = '0;
            col_pos_in = pos_ctl.last_col ? '0 : col_pos_ff + CW'(1);
         end else begin
            row_pos_in = row_pos_ff + RW'(1);
         end
      end
   end

   // ---------------- update stage ----------------
   assign s1_adv    = s1_valid_ff && (!s1_ctl_ff.last_col || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;

   always_comb begin
      base_sum = fwd_ff ? wb_sum_ff : rd_sum_ff;
      base_col = fwd_ff ? wb_col_ff : rd_col_ff;
      take_new = s1_ctl_ff.first_col || (s1_sum_ff < base_sum);
      new_sum  = take_new ? s1_sum_ff : base_sum;
      new_col  = take_new ? s1_col_ff : base_col;

      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      // the row written this cycle is the one read now: take the written value
      fwd_in = req_xfer ? (s1_adv && (s1_row_ff == row_pos_ff)) : fwd_ff;

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_ctl_ff.last_col) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= DIM_RESET;
         cols_cfg_ff  <= DIM_RESET;
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sum_ff <= {req_cell_value[DATA_WIDTH-1], req_cell_value}
                    + {req_column_offset[DATA_WIDTH-1], req_column_offset};
         s1_row_ff <= row_pos_ff;
         s1_col_ff <= IDX_OUT_W'(col_pos_ff);
         s1_ctl_ff <= pos_ctl;
      end
      if (s1_adv) begin
         wb_sum_ff <= new_sum;
         wb_col_ff <= new_col;
      end
      if (s1_adv && s1_ctl_ff.last_col) begin
         rsp_min_ff    <= new_sum;
         rsp_argmin_ff <= new_col;
         rsp_row_ff    <= IDX_OUT_W'(s1_row_ff);
         rsp_done_ff   <= s1_ctl_ff.last_row;
      end
   end

   // row memories: read on transfer, write back as the stage advances
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         best_sum_ff[s1_row_ff] <= new_sum;
      end
      if (req_xfer) begin
         rd_sum_ff <= best_sum_ff[row_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         best_column_ff[s1_row_ff] <= new_col;
      end
      if (req_xfer) begin
         rd_col_ff <= best_column_ff[row_pos_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_min    = rsp_min_ff;
   assign rsp_row_argmin = rsp_argmin_ff;
   assign rsp_row_number = rsp_row_ff;
   assign rsp_pass_done  = rsp_done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mprr_checker.sv =====
// Port-level checks for the min-plus row reduce block, bound to its top level.
`default_nettype none

`include "min_plus_row_reduce_macros.svh"

module mprr_checker #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [DATA_WIDTH:0]   rsp_row_min,
   input wire logic [9:0]            rsp_row_argmin,
   input wire logic [9:0]            rsp_row_number,
   input wire logic                  rsp_pass_done
);

   logic                req_xfer;
   logic                req_xfer_ff;
   logic                no_recent_xfer;
   logic [DATA_WIDTH:0] prev_min_ff;
   logic [9:0]          prev_argmin_ff;
   logic [9:0]          prev_row_ff;
   logic                prev_done_ff;
   logic                rsp_hold;

   assign req_xfer = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_xfer_ff <= 1'b0;
      end else begin
         req_xfer_ff <= req_xfer;
      end
   end

   // previous cycle's payload
   always_ff @(posedge clock) begin
      prev_min_ff    <= rsp_row_min;
      prev_argmin_ff <= rsp_row_argmin;
      prev_row_ff    <= rsp_row_number;
      prev_done_ff   <= rsp_pass_done;
   end

   assign no_recent_xfer = !req_xfer_ff && !req_xfer;
   assign rsp_hold = (rsp_row_min == prev_min_ff) && (rsp_row_argmin == prev_argmin_ff)
                  && (rsp_row_number == prev_row_ff) && (rsp_pass_done == prev_done_ff);

   // a stalled result keeps its payload
   `MPRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && rsp_hold)
   // reset leaves no result pending
   `MPRR_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   // no result appears unless req_xfer or its registered copy req_xfer_ff was set
   `MPRR_ASSERT_NEXT(a_no_phantom, clock, reset, no_recent_xfer && !rsp_valid, !rsp_valid)

endmodule

bind min_plus_row_reduce mprr_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_mprr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_row_min    (rsp_row_min),
   .rsp_row_argmin (rsp_row_argmin),
   .rsp_row_number (rsp_row_number),
   .rsp_pass_done  (rsp_pass_done)
);

`default_nettype wire
